FILE: rtl/hwar_pkg.sv
// Package for the world-to-axial hex lookup.
// Holds the fixed-point constants, output limits and the reciprocal status type.
// No dependencies.
package hwar_pkg;

   localparam int unsigned OUT_WIDTH  = 24;
   localparam int unsigned SIZE_WIDTH = 16;
   localparam int unsigned RECIP_WIDTH = 32;
   localparam int unsigned ERR_WIDTH  = 16;

   // Q2.30 constants: sqrt3/3, 1/3, 2/3
   localparam logic signed [31:0] C_Q          = 32'sd619925131;
   localparam logic signed [31:0] C_THIRD      = 32'sd357913941;
   localparam logic signed [31:0] C_TWO_THIRDS = 32'sd715827883;

   localparam logic [SIZE_WIDTH-1:0]  SIZE_RESET  = 16'd256;
   localparam logic [RECIP_WIDTH-1:0] RECIP_RESET = 32'h0100_0000;

   localparam int OUT_MAX = 8388607;
   localparam int OUT_MIN = -8388608;

   typedef struct packed {
      logic                   busy;
      logic [RECIP_WIDTH-1:0] value;
   } recip_status_type;

endpackage

FILE: rtl/hwar_req_if.sv
// Request channel of the hex lookup: valid, ready and the world point.
// No dependencies.
interface hwar_req_if #(
   parameter int WORLD_WIDTH = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [WORLD_WIDTH-1:0] world_x;
   logic signed [WORLD_WIDTH-1:0] world_z;

   modport source (output valid, world_x, world_z, input ready);
   modport sink   (input valid, world_x, world_z, output ready);
endinterface

FILE: rtl/hwar_rsp_if.sv
// Response channel of the hex lookup: valid, ready and the axial hex.
// Depends on hwar_pkg for the output width.
interface hwar_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [hwar_pkg::OUT_WIDTH-1:0] axial_q;
   logic signed [hwar_pkg::OUT_WIDTH-1:0] axial_r;
   logic                                 clipped;

   modport source (output valid, axial_q, axial_r, clipped, input ready);
   modport sink   (input valid, axial_q, axial_r, clipped, output ready);
endinterface

FILE: rtl/hwar_recip.sv
// Hex size register and bit-serial reciprocal unit: round(2^32 / size), clamped.
// One quotient bit per cycle while busy. Depends on hwar_pkg.
module hwar_recip (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [hwar_pkg::SIZE_WIDTH-1:0]       csr_wr_data,
   output hwar_pkg::recip_status_type            status
);
   import hwar_pkg::*;

   localparam int unsigned DIV_STEPS = RECIP_WIDTH + 1;
   localparam int unsigned CNT_WIDTH = $clog2(DIV_STEPS + 1);

   logic                   busy_ff, busy_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic [RECIP_WIDTH:0]   quo_ff, quo_in;
   logic [SIZE_WIDTH-1:0]  rem_ff, rem_in;
   logic [SIZE_WIDTH-1:0]  div_ff, div_in;
   logic [RECIP_WIDTH-1:0] recip_ff, recip_in;

   logic [SIZE_WIDTH-1:0]  size_d;
   logic [SIZE_WIDTH:0]    rem_sh;
   logic [SIZE_WIDTH:0]    rem_sub;
   logic                   fits;

   always_comb begin
      size_d   = (csr_wr_data == '0) ? SIZE_WIDTH'(1) : csr_wr_data;
      rem_sh   = {rem_ff, quo_ff[RECIP_WIDTH]};
      rem_sub  = rem_sh - {1'b0, div_ff};
      fits     = (rem_sh >= {1'b0, div_ff});
      busy_in  = busy_ff;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      recip_in = recip_ff;
      if (csr_wr_en) begin
         // numerator 2^32 + size/2, quotient shifts in from the bottom
         busy_in  = 1'b1;
         count_in = CNT_WIDTH'(DIV_STEPS);
         quo_in   = {1'b1, {(RECIP_WIDTH-SIZE_WIDTH+1){1'b0}}, size_d[SIZE_WIDTH-1:1]};
         rem_in   = '0;
         div_in   = size_d;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[RECIP_WIDTH-1:0], fits};
         rem_in   = fits ? rem_sub[SIZE_WIDTH-1:0] : rem_sh[SIZE_WIDTH-1:0];
         count_in = count_ff - CNT_WIDTH'(1);
         if (count_ff == CNT_WIDTH'(1)) begin
            busy_in  = 1'b0;
            recip_in = quo_in[RECIP_WIDTH] ? '1 : quo_in[RECIP_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
         recip_ff <= RECIP_RESET;
         div_ff   <= SIZE_RESET;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
         recip_ff <= recip_in;
         div_ff   <= div_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign status.busy  = busy_ff;
   assign status.value = recip_ff;

endmodule

FILE: rtl/hwar_project.sv
// Four-stage projection: constant products, axial numerators, reciprocal
// partial products, then fractional q and r with 16 fractional bits. Depends on hwar_pkg.
module hwar_project #(
   parameter int WORLD_WIDTH = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic signed [WORLD_WIDTH-1:0]        world_x,
   input  logic signed [WORLD_WIDTH-1:0]        world_z,
   input  logic [hwar_pkg::RECIP_WIDTH-1:0]     recip,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [WORLD_WIDTH+18:0]       frac_q,
   output logic signed [WORLD_WIDTH+18:0]       frac_r
);
   import hwar_pkg::*;

   localparam int PW = WORLD_WIDTH + 32;  // product width
   localparam int MW = WORLD_WIDTH + 30;  // numerator magnitude width
   localparam int FW = WORLD_WIDTH + 19;  // fraction width
   localparam int NS = 4;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] ld;

   logic signed [PW-1:0] px_ff, pt_ff, pb_ff;
   logic signed [PW-1:0] px_in, pt_in, pb_in;

   logic signed [PW-1:0] a_num, a_abs, b_abs;
   logic                 neg_a_ff, neg_b_ff, neg_a_in, neg_b_in;
   logic [MW-1:0]        mag_a_ff, mag_b_ff, mag_a_in, mag_b_in;

   logic [MW-1:0]        ph_a_ff, ph_b_ff, ph_a_in, ph_b_in;
   logic [63:0]          pl_a_full, pl_b_full;
   logic [31:0]          pl_a_ff, pl_b_ff;
   logic                 neg_a3_ff, neg_b3_ff;

   logic [MW:0]          t_a, t_b;
   logic signed [FW-1:0] r_a, r_b;
   logic signed [FW-1:0] fq_ff, fr_ff, fq_in, fr_in;

   always_comb begin
      ld[NS-1] = !v_ff[NS-1] || out_ready;
      for (int i = NS - 2; i >= 0; i--) begin
         ld[i] = !v_ff[i] || ld[i+1];
      end
   end

   always_comb begin
      px_in = PW'(world_x) * PW'(C_Q);
      pt_in = PW'(world_z) * PW'(C_THIRD);
      pb_in = PW'(world_z) * PW'(C_TWO_THIRDS);

      a_num    = px_ff - pt_ff;
      neg_a_in = a_num[PW-1];
      neg_b_in = pb_ff[PW-1];
      a_abs    = neg_a_in ? -a_num : a_num;
      b_abs    = neg_b_in ? -pb_ff : pb_ff;
      mag_a_in = a_abs[MW-1:0];
      mag_b_in = b_abs[MW-1:0];

      ph_a_in   = MW'(mag_a_ff[MW-1:32] * recip);
      ph_b_in   = MW'(mag_b_ff[MW-1:32] * recip);
      pl_a_full = mag_a_ff[31:0] * recip;
      pl_b_full = mag_b_ff[31:0] * recip;

      t_a   = (MW+1)'(ph_a_ff) + (MW+1)'(pl_a_ff);
      t_b   = (MW+1)'(ph_b_ff) + (MW+1)'(pl_b_ff);
      r_a   = $signed(FW'(t_a[MW:14]));
      r_b   = $signed(FW'(t_b[MW:14]));
      fq_in = neg_a3_ff ? -r_a : r_a;
      fr_in = neg_b3_ff ? -r_b : r_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {ld[3] ? v_ff[2] : v_ff[3],
                  ld[2] ? v_ff[1] : v_ff[2],
                  ld[1] ? v_ff[0] : v_ff[1],
                  ld[0] ? in_valid : v_ff[0]};
      end
      if (ld[0]) begin
         px_ff <= px_in;
         pt_ff <= pt_in;
         pb_ff <= pb_in;
      end
      if (ld[1]) begin
         neg_a_ff <= neg_a_in;
         neg_b_ff <= neg_b_in;
         mag_a_ff <= mag_a_in;
         mag_b_ff <= mag_b_in;
      end
      if (ld[2]) begin
         ph_a_ff   <= ph_a_in;
         ph_b_ff   <= ph_b_in;
         pl_a_ff   <= pl_a_full[63:32];
         pl_b_ff   <= pl_b_full[63:32];
         neg_a3_ff <= neg_a_ff;
         neg_b3_ff <= neg_b_ff;
      end
      if (ld[3]) begin
         fq_ff <= fq_in;
         fr_ff <= fr_in;
      end
   end

   assign in_ready  = ld[0];
   assign out_valid = v_ff[NS-1];
   assign frac_q    = fq_ff;
   assign frac_r    = fr_ff;

endmodule

FILE: rtl/hwar_round.sv
// Three-stage cube rounding: third coordinate and magnitudes, half-away rounding
// with errors, then rebuild and saturation into the output register. Depends on hwar_pkg.
module hwar_round #(
   parameter int WORLD_WIDTH = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic signed [WORLD_WIDTH+18:0]         frac_q,
   input  logic signed [WORLD_WIDTH+18:0]         frac_r,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic signed [hwar_pkg::OUT_WIDTH-1:0]  axial_q,
   output logic signed [hwar_pkg::OUT_WIDTH-1:0]  axial_r,
   output logic                                   clipped
);
   import hwar_pkg::*;

   localparam int FW = WORLD_WIDTH + 19;        // fraction width
   localparam int NMW = FW - 15;                // rounded magnitude width
   localparam int NW = NMW + 1;                 // rounded signed width
   localparam int BW = NW + 1;                  // rebuilt width
   localparam int CW = (BW > OUT_WIDTH + 1) ? BW : OUT_WIDTH + 1;
   localparam logic signed [CW-1:0] SAT_MAX = CW'(OUT_MAX);
   localparam logic signed [CW-1:0] SAT_MIN = CW'(OUT_MIN);
   localparam int NS = 3;

   // lanes: 0 = x (q), 1 = y, 2 = z (r)
   logic [NS-1:0] v_ff;
   logic [NS-1:0] ld;

   logic signed [FW-1:0] fy;
   logic signed [FW-1:0] fv [3];
   logic signed [FW-1:0] fabs [3];
   logic [2:0]           neg_ff, neg_in;
   logic [FW-1:0]        mag_ff [3];
   logic [FW-1:0]        mag_in [3];

   logic [FW:0]             rsum [3];
   logic [NMW-1:0]          nmag [3];
   logic [FW:0]             nsh [3];
   logic [FW:0]             mext [3];
   logic [FW:0]             ediff [3];
   logic signed [NW-1:0]    n_ff [3];
   logic signed [NW-1:0]    n_in [3];
   logic [ERR_WIDTH-1:0]    e_ff [3];
   logic [ERR_WIDTH-1:0]    e_in [3];

   logic signed [BW-1:0] bx, by, bz, q_sel, r_sel;
   logic signed [CW-1:0] q_c, r_c;
   logic signed [OUT_WIDTH-1:0] q_in, r_in, q_ff, r_ff;
   logic                 clip_q, clip_r, clip_ff;

   always_comb begin
      ld[NS-1] = !v_ff[NS-1] || out_ready;
      for (int i = NS - 2; i >= 0; i--) begin
         ld[i] = !v_ff[i] || ld[i+1];
      end
   end

   always_comb begin
      fy    = -frac_q - frac_r;
      fv[0] = frac_q;
      fv[1] = fy;
      fv[2] = frac_r;
      for (int k = 0; k < 3; k++) begin
         neg_in[k] = fv[k][FW-1];
         fabs[k]   = neg_in[k] ? -fv[k] : fv[k];
         mag_in[k] = fabs[k];
      end

      for (int k = 0; k < 3; k++) begin
         rsum[k]  = (FW+1)'(mag_ff[k]) + (FW+1)'(32768);
         nmag[k]  = rsum[k][FW:16];
         nsh[k]   = {nmag[k], 16'b0};
         mext[k]  = (FW+1)'(mag_ff[k]);
         ediff[k] = (nsh[k] >= mext[k]) ? nsh[k] - mext[k] : mext[k] - nsh[k];
         e_in[k]  = ediff[k][ERR_WIDTH-1:0];
         n_in[k]  = neg_ff[k] ? -$signed(NW'(nmag[k])) : $signed(NW'(nmag[k]));
      end

      bx    = BW'(n_ff[0]);
      by    = BW'(n_ff[1]);
      bz    = BW'(n_ff[2]);
      q_sel = bx;
      r_sel = bz;
      if (e_ff[0] > e_ff[1] && e_ff[0] > e_ff[2]) begin
         q_sel = -by - bz;
      end else if (e_ff[1] > e_ff[2]) begin
         q_sel = bx;
      end else begin
         r_sel = -bx - by;
      end
      q_c    = CW'(q_sel);
      r_c    = CW'(r_sel);
      clip_q = (q_c > SAT_MAX) || (q_c < SAT_MIN);
      clip_r = (r_c > SAT_MAX) || (r_c < SAT_MIN);
      q_in   = (q_c > SAT_MAX) ? SAT_MAX[OUT_WIDTH-1:0] :
               (q_c < SAT_MIN) ? SAT_MIN[OUT_WIDTH-1:0] : q_c[OUT_WIDTH-1:0];
      r_in   = (r_c > SAT_MAX) ? SAT_MAX[OUT_WIDTH-1:0] :
               (r_c < SAT_MIN) ? SAT_MIN[OUT_WIDTH-1:0] : r_c[OUT_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {ld[2] ? v_ff[1] : v_ff[2],
                  ld[1] ? v_ff[0] : v_ff[1],
                  ld[0] ? in_valid : v_ff[0]};
      end
      if (ld[0]) begin
         neg_ff <= neg_in;
         mag_ff <= mag_in;
      end
      if (ld[1]) begin
         n_ff <= n_in;
         e_ff <= e_in;
      end
      if (ld[2]) begin
         q_ff    <= q_in;
         r_ff    <= r_in;
         clip_ff <= clip_q || clip_r;
      end
   end

   assign in_ready  = ld[0];
   assign out_valid = v_ff[NS-1];
   assign axial_q   = q_ff;
   assign axial_r   = r_ff;
   assign clipped   = clip_ff;

endmodule

FILE: rtl/hex_world_to_axial_round.sv
// Throughput: one request per cycle while the response side is ready and no reciprocal rebuild is busy.
// Stages: three in the projection multipliers and adder, one combining the
// reciprocal partial products, three in rounding and rebuild.
// A hex size write runs the bit-serial reciprocal, refusing requests while it is busy.
// Reset (synchronous, active high) empties the pipeline and loads hex size 256.
module hex_world_to_axial_round #(
   parameter int WORLD_WIDTH = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   hwar_req_if.sink                            req_ch,
   hwar_rsp_if.source                          rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [hwar_pkg::SIZE_WIDTH-1:0]     csr_wr_data
);
   import hwar_pkg::*;

   recip_status_type                 recip_status;
   logic                             proj_in_ready;
   logic                             proj_valid;
   logic                             round_ready;
   logic signed [WORLD_WIDTH+18:0]   frac_q;
   logic signed [WORLD_WIDTH+18:0]   frac_r;

   hwar_recip u_recip (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (recip_status)
   );

   hwar_project #(
      .WORLD_WIDTH (WORLD_WIDTH)
   ) u_project (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid && !recip_status.busy),
      .in_ready  (proj_in_ready),
      .world_x   (req_ch.world_x),
      .world_z   (req_ch.world_z),
      .recip     (recip_status.value),
      .out_valid (proj_valid),
      .out_ready (round_ready),
      .frac_q    (frac_q),
      .frac_r    (frac_r)
   );

   hwar_round #(
      .WORLD_WIDTH (WORLD_WIDTH)
   ) u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (proj_valid),
      .in_ready  (round_ready),
      .frac_q    (frac_q),
      .frac_r    (frac_r),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .axial_q   (rsp_ch.axial_q),
      .axial_r   (rsp_ch.axial_r),
      .clipped   (rsp_ch.clipped)
   );

   // hold requests off while the reciprocal is rebuilt
   assign req_ch.ready = proj_in_ready && !recip_status.busy;

endmodule
